// File: rtl/ordered_key_value_table_macros.svh
// Assertion macros for the ordered key/value table checker.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef ORDERED_KEY_VALUE_TABLE_MACROS_SVH
`define ORDERED_KEY_VALUE_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OKVT_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OKVT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/okvt_pkg.sv
// Shared types, codes and defaults for the ordered key/value table.
// No dependencies; the controller, datapath, top and checker import this package.
`timescale 1ns / 1ps
`default_nettype none

package okvt_pkg;

    localparam int KEY_W        = 32;
    localparam int DATA_W       = 64;
    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 32;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;
    localparam logic [1:0] CMD_GET    = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_ITEM = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data_in;
    } okvt_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] data_out;
    } okvt_out_t;

    typedef struct packed {
        logic       load;
        logic       scan_start;
        logic       shift_start;
        logic       rd_issue;
        logic       wr_append;
        logic       wr_update;
        logic       wr_shift;
        logic       cnt_dec;
        logic       res_load;
        logic       res_data;
        logic [1:0] res_status;
        logic       out_load;
    } okvt_ctl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       full;
        logic       ptr_end;
        logic       rd_vld;
        logic       rd_match;
        logic       out_busy;
    } okvt_sts_t;

endpackage

`default_nettype wire

// File: rtl/okvt_ctrl.sv
// Controller state machine for the ordered key/value table.
// Depends on okvt_pkg; drives the datapath through okvt_ctl_t commands.
`timescale 1ns / 1ps
`default_nettype none

module okvt_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire okvt_pkg::okvt_sts_t sts,
    output okvt_pkg::okvt_ctl_t      ctl
);
    import okvt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT,
        S_RESPOND
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        req_stall  = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.cmd == CMD_APPEND)
                begin
                    ctl.res_load = 1'b1;
                    if (sts.full)
                    begin
                        ctl.res_status = ST_FULL;
                    end
                    else
                    begin
                        ctl.wr_append  = 1'b1;
                        ctl.res_status = ST_OK;
                    end
                    state_next = S_RESPOND;
                end
                else
                begin
                    ctl.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.rd_match)
                begin
                    case (sts.cmd)
                        CMD_DELETE:
                        begin
                            ctl.shift_start = 1'b1;
                            state_next      = S_SHIFT;
                        end
                        CMD_UPDATE:
                        begin
                            ctl.wr_update  = 1'b1;
                            ctl.res_load   = 1'b1;
                            ctl.res_status = ST_OK;
                            state_next     = S_RESPOND;
                        end
                        default:
                        begin
                            ctl.res_load   = 1'b1;
                            ctl.res_data   = 1'b1;
                            ctl.res_status = ST_OK;
                            state_next     = S_RESPOND;
                        end
                    endcase
                end
                else if (sts.ptr_end)
                begin
                    ctl.res_load   = 1'b1;
                    ctl.res_status = ST_NO_ITEM;
                    state_next     = S_RESPOND;
                end
                else
                begin
                    ctl.rd_issue = 1'b1;
                end
            end
            S_SHIFT:
            begin
                ctl.wr_shift = sts.rd_vld;
                if (sts.ptr_end)
                begin
                    ctl.cnt_dec    = 1'b1;
                    ctl.res_load   = 1'b1;
                    ctl.res_status = ST_OK;
                    state_next     = S_RESPOND;
                end
                else
                begin
                    ctl.rd_issue = 1'b1;
                end
            end
            S_RESPOND:
            begin
                if (!sts.out_busy)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/okvt_datapath.sv
// Datapath of the ordered key/value table: entry memory, scan pointer,
// match compare, fill count and result registers. Depends on okvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module okvt_datapath #(
    parameter int DEPTH    = okvt_pkg::DEPTH_DEF,
    parameter int KEY_BITS = okvt_pkg::KEY_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire okvt_pkg::okvt_in_t  req,
    input  wire logic                rsp_stall,
    output logic                     rsp_valid,
    output okvt_pkg::okvt_out_t      rsp,
    input  wire okvt_pkg::okvt_ctl_t ctl,
    output okvt_pkg::okvt_sts_t      sts
);
    import okvt_pkg::*;

    localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [KW-1:0]     key_mem [DEPTH];
    logic [DATA_W-1:0] data_mem [DEPTH];

    logic [1:0]        cmd_reg;
    logic [KW-1:0]     key_reg;
    logic [DATA_W-1:0] data_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     ptr_reg;
    logic              rd_vld_reg;
    logic [IW-1:0]     rd_idx_reg;
    logic [KW-1:0]     rd_key_reg;
    logic [DATA_W-1:0] rd_data_reg;
    okvt_out_t         res_reg;
    logic              out_valid_reg;
    okvt_out_t         out_reg;

    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [KW-1:0]     wr_key;
    logic [DATA_W-1:0] wr_data;

    always_comb
    begin
        wr_en = ctl.wr_append | ctl.wr_update | ctl.wr_shift;
        if (ctl.wr_shift)
        begin
            wr_addr = rd_idx_reg - IW'(1);
            wr_key  = rd_key_reg;
            wr_data = rd_data_reg;
        end
        else if (ctl.wr_update)
        begin
            wr_addr = rd_idx_reg;
            wr_key  = key_reg;
            wr_data = data_reg;
        end
        else
        begin
            wr_addr = count_reg[IW-1:0];
            wr_key  = key_reg;
            wr_data = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]  <= wr_key;
            data_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_issue)
        begin
            rd_key_reg  <= key_mem[ptr_reg[IW-1:0]];
            rd_data_reg <= data_mem[ptr_reg[IW-1:0]];
            rd_idx_reg  <= ptr_reg[IW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_append)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (ctl.cnt_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end

            if (ctl.scan_start)
            begin
                ptr_reg <= '0;
            end
            else if (ctl.shift_start)
            begin
                ptr_reg <= CW'(rd_idx_reg) + CW'(1);
            end
            else if (ctl.rd_issue)
            begin
                ptr_reg <= ptr_reg + CW'(1);
            end

            rd_vld_reg <= ctl.rd_issue;

            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= req.cmd;
            key_reg  <= req.key[KW-1:0];
            data_reg <= req.data_in;
        end
        if (ctl.res_load)
        begin
            res_reg.status   <= ctl.res_status;
            res_reg.data_out <= ctl.res_data ? rd_data_reg : '0;
        end
        if (ctl.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    always_comb
    begin
        sts.cmd      = cmd_reg;
        sts.full     = (count_reg == CW'(DEPTH));
        sts.ptr_end  = (ptr_reg == count_reg);
        sts.rd_vld   = rd_vld_reg;
        sts.rd_match = rd_vld_reg && (rd_key_reg == key_reg);
        sts.out_busy = out_valid_reg && rsp_stall;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

// File: rtl/ordered_key_value_table.sv
// Top level of the ordered key/value table: controller plus datapath.
// Depends on okvt_pkg, okvt_ctrl and okvt_datapath.
//
//   Channel  Signals                  Payload
//   req      req_valid, req_stall     okvt_in_t  (cmd, key, data_in)
//   rsp      rsp_valid, rsp_stall     okvt_out_t (status, data_out)
//
// An append goes from dispatch straight to the response register, with no scan.
// Delete, update and get read the entries up to the first match (at most DEPTH),
// one per cycle from the memory; a delete then moves each entry behind the match up.
// After reset the table is empty; no clearing pass is needed.
// A stalled response holds; the next transaction is accepted meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module ordered_key_value_table #(
    parameter int DEPTH    = okvt_pkg::DEPTH_DEF,
    parameter int KEY_BITS = okvt_pkg::KEY_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire okvt_pkg::okvt_in_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output okvt_pkg::okvt_out_t     rsp
);
    import okvt_pkg::*;

    okvt_ctl_t ctl;
    okvt_sts_t sts;

    okvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    okvt_datapath #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// File: rtl/okvt_checker.sv
// Port-level assertions for the ordered key/value table, bound to the top.
// Depends on okvt_pkg and ordered_key_value_table_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_key_value_table_macros.svh"

module okvt_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_stall,
    input wire okvt_pkg::okvt_in_t req,
    input wire logic               rsp_valid,
    input wire logic               rsp_stall,
    input wire okvt_pkg::okvt_out_t rsp
);
    import okvt_pkg::*;

    `OKVT_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accepted transaction did not make the block busy")
    `OKVT_ASSERT_SAME(a_rsp_rise_from_busy, $rose(rsp_valid), $past(req_stall), "response appeared while the block was idle")
    `OKVT_ASSERT_SAME(a_data_zero_on_fail, rsp_valid && (rsp.status != ST_OK), rsp.data_out == '0, "nonzero data on a failed response")
    `OKVT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")

endmodule

bind ordered_key_value_table okvt_checker u_checker (.*);

`default_nettype wire
